/* design/rhsv_pkg.sv */
// Shared constants for the byte-pixel RGB to HSV converter.
// No dependencies; used by rhsv_scale_rom and rgb_to_hsv_byte_pixel_top.
`timescale 1ns / 1ps

package rhsv_pkg;

  localparam int unsigned ShiftBits = 12;
  localparam int unsigned RoundHalf = 1 << (ShiftBits - 1);
  localparam int unsigned HueWrap   = 180;
  localparam int unsigned SatNum    = 1044480;  // 255 * 4096
  localparam int unsigned HueNum    = 122880;   // 30 * 4096

  localparam int unsigned PixW  = 8;
  localparam int unsigned TermW = 12;  // signed hue sector term, -255..1275
  localparam int unsigned T1W   = 20;  // largest entry 1044480
  localparam int unsigned T2W   = 17;  // largest entry 122880
  localparam int unsigned TabN  = 1 << PixW;

endpackage

/* design/rhsv_scale_rom.sv */
// Constant reciprocal tables for saturation (T1) and hue (T2) scaling.
// Entries are round-to-nearest, built at elaboration; depends on rhsv_pkg.
`timescale 1ns / 1ps

module rhsv_scale_rom import rhsv_pkg::*; (
  input  logic [PixW-1:0] max_val,
  input  logic [PixW-1:0] diff_val,
  output logic [T1W-1:0]  sat_scale,
  output logic [T2W-1:0]  hue_scale
);

  logic [T1W-1:0] t1_tab [TabN];
  logic [T2W-1:0] t2_tab [TabN];

  for (genvar i = 0; i < TabN; i++) begin : g_tab
    if (i == 0) begin : g_zero
      assign t1_tab[i] = '0;
      assign t2_tab[i] = '0;
    end else begin : g_val
      localparam logic [T1W-1:0] T1Val = T1W'((2 * SatNum + i) / (2 * i));
      localparam logic [T2W-1:0] T2Val = T2W'((2 * HueNum + i) / (2 * i));
      assign t1_tab[i] = T1Val;
      assign t2_tab[i] = T2Val;
    end
  end

  assign sat_scale = t1_tab[max_val];
  assign hue_scale = t2_tab[diff_val];

endmodule

/* design/rgb_to_hsv_byte_pixel_top.sv */
// Byte-pixel RGB to HSV converter, four-register pipeline.
// Depends on rhsv_pkg and rhsv_scale_rom.
//
// channel  direction  handshake           payload
// in_      input      in_valid/in_stall   in_first_channel, in_second_channel,
//                                         in_third_channel
// out_     output     out_valid/out_stall out_hue, out_saturation, out_brightness
// cfg_     input      cfg_valid/cfg_ready cfg_blue_first
//
// One pixel per clock while out_stall is low; each pixel passes all four registers.
// Stages: input register, max/min/sector term, table lookup, multiply and round.
// Each stage loads when empty or when the stage after it moves on, so bubbles
// close up under out_stall; in_stall rises only when all four stages are full.
// rst_n (synchronous) empties the pipe and clears blue_first; cfg_ready is
// always high.
`timescale 1ns / 1ps

module rgb_to_hsv_byte_pixel_top import rhsv_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [PixW-1:0] in_first_channel,
  input  logic [PixW-1:0] in_second_channel,
  input  logic [PixW-1:0] in_third_channel,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [PixW-1:0] out_hue,
  output logic [PixW-1:0] out_saturation,
  output logic [PixW-1:0] out_brightness,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_blue_first
);

  logic blue_first_r;

  // stage valids and load enables
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic en1, en2, en3, en_out;

  // stage 1: channels in R,G,B order
  logic [PixW-1:0] s1_r_r, s1_g_r, s1_b_r;
  // stage 2
  logic [PixW-1:0]  s2_max_r, s2_diff_r;
  logic [TermW-1:0] s2_term_r;
  // stage 3
  logic [PixW-1:0]  s3_max_r, s3_diff_r;
  logic [TermW-1:0] s3_term_r;
  logic [T1W-1:0]   s3_t1_r;
  logic [T2W-1:0]   s3_t2_r;
  // result
  logic [PixW-1:0] hue_r, sat_r, bright_r;

  logic [PixW-1:0]  max_nxt, min_nxt, diff_nxt;
  logic [TermW-1:0] term_nxt;
  logic [T1W-1:0]   t1_nxt;
  logic [T2W-1:0]   t2_nxt;

  logic [PixW+T1W-1:0]         sat_prod;
  logic [PixW+T1W:0]           sat_sum;
  logic [PixW+T1W-ShiftBits:0] sat_q;
  logic [PixW-1:0]             sat_nxt;

  localparam int unsigned HueProdW = TermW + T2W + 1;
  localparam int unsigned HueQW    = HueProdW - ShiftBits;
  logic signed [HueProdW-1:0] hue_prod, hue_sum, hue_sh;
  logic signed [HueQW-1:0]    hue_q, hue_w;
  logic [PixW-1:0]            hue_nxt;

  assign cfg_ready = 1'b1;

  assign en_out   = !out_v_r || !out_stall;
  assign en3      = !s3_v_r || en_out;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_stall = !en1;

  // max, min and hue sector term; ties go red, then green
  always_comb begin
    max_nxt = s1_r_r;
    min_nxt = s1_r_r;
    if (s1_g_r > max_nxt) max_nxt = s1_g_r;
    if (s1_b_r > max_nxt) max_nxt = s1_b_r;
    if (s1_g_r < min_nxt) min_nxt = s1_g_r;
    if (s1_b_r < min_nxt) min_nxt = s1_b_r;
    diff_nxt = max_nxt - min_nxt;
    if (max_nxt == s1_r_r) begin
      term_nxt = TermW'(s1_g_r) - TermW'(s1_b_r);
    end else if (max_nxt == s1_g_r) begin
      term_nxt = TermW'(s1_b_r) - TermW'(s1_r_r) + (TermW'(diff_nxt) << 1);
    end else begin
      term_nxt = TermW'(s1_r_r) - TermW'(s1_g_r) + (TermW'(diff_nxt) << 2);
    end
  end

  rhsv_scale_rom u_rom (
    .max_val   (s2_max_r),
    .diff_val  (s2_diff_r),
    .sat_scale (t1_nxt),
    .hue_scale (t2_nxt)
  );

  // scale, round half up (floor after adding half), wrap negative hue by 180, clamp to a byte
  always_comb begin
    sat_prod = (PixW+T1W)'(s3_diff_r) * (PixW+T1W)'(s3_t1_r);
    sat_sum  = (PixW+T1W+1)'(sat_prod) + (PixW+T1W+1)'(RoundHalf);
    sat_q    = sat_sum[PixW+T1W:ShiftBits];
    sat_nxt  = (|sat_q[PixW+T1W-ShiftBits:PixW]) ? '1 : sat_q[PixW-1:0];

    hue_prod = $signed({{(HueProdW-TermW){s3_term_r[TermW-1]}}, s3_term_r})
             * $signed({{(HueProdW-T2W){1'b0}}, s3_t2_r});
    hue_sum  = hue_prod + $signed(HueProdW'(RoundHalf));
    hue_sh   = hue_sum >>> ShiftBits;
    hue_q    = hue_sh[HueQW-1:0];
    hue_w    = hue_q[HueQW-1] ? hue_q + $signed(HueQW'(HueWrap)) : hue_q;
    if (hue_w[HueQW-1]) begin
      hue_nxt = '0;
    end else if (|hue_w[HueQW-2:PixW]) begin
      hue_nxt = '1;
    end else begin
      hue_nxt = hue_w[PixW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blue_first_r <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) blue_first_r <= cfg_blue_first;
      if (en1)    s1_v_r  <= in_valid;
      if (en2)    s2_v_r  <= s1_v_r;
      if (en3)    s3_v_r  <= s2_v_r;
      if (en_out) out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_g_r <= in_second_channel;
      s1_r_r <= blue_first_r ? in_third_channel : in_first_channel;
      s1_b_r <= blue_first_r ? in_first_channel : in_third_channel;
    end
    if (en2 && s1_v_r) begin
      s2_max_r  <= max_nxt;
      s2_diff_r <= diff_nxt;
      s2_term_r <= term_nxt;
    end
    if (en3 && s2_v_r) begin
      s3_max_r  <= s2_max_r;
      s3_diff_r <= s2_diff_r;
      s3_term_r <= s2_term_r;
      s3_t1_r   <= t1_nxt;
      s3_t2_r   <= t2_nxt;
    end
    if (en_out && s3_v_r) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= s3_max_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;

  // black pixel: both tables read zero
  a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_brightness == '0) |-> (out_saturation == '0 && out_hue == '0))
    else $error("black pixel gave nonzero hue or saturation");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue <= PixW'(HueWrap)))
    else $error("hue beyond wrap value");

  // back-pressure only when every stage holds a pixel
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && s3_v_r && out_v_r && out_stall))
    else $error("input stalled with room in the pipe");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !out_stall) |=> out_valid)
    else $error("stage 3 pixel not moved to output");

endmodule
